// ===== sv/lhmpq_pkg.sv =====
// Types, constants and helper functions shared by the line hull query block.
`default_nettype none
package lhmpq_pkg;

  localparam int SLOPE_W = 22;
  localparam int ICPT_W  = 42;
  localparam int VAL_W   = 43;
  localparam int STAT_W  = 2;
  localparam int HIDX_W  = 2;
  localparam int ADIF_W  = SLOPE_W + 1;
  localparam int BDIF_W  = ICPT_W + 1;
  localparam int BLO_W   = 21;
  localparam int MOP_W   = 24;
  localparam int PROD_W  = 2 * MOP_W;
  localparam int ACC_W   = 64;

  localparam logic signed [SLOPE_W-1:0] SLOPE_LIM = 22'sd1048576;
  localparam logic signed [ICPT_W-1:0]  ICPT_LIM  = 42'sd1099511627776;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  icpt;
  } line_t;

  typedef struct packed {
    logic signed [MOP_W-1:0] op_a;
    logic signed [MOP_W-1:0] op_b;
  } mul_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_CHK,
    S_ADD_RD0,
    S_ADD_RD1,
    S_ADD_LAT,
    S_ADD_DIF,
    S_ADD_MUL,
    S_ADD_CMP,
    S_ADD_PUSH,
    S_QRY_CHK,
    S_QRY_RD0,
    S_QRY_RD1,
    S_QRY_LAT,
    S_QRY_M0,
    S_QRY_M1,
    S_QRY_M2,
    S_QRY_CMP,
    S_DONE
  } state_t;

  function automatic logic signed [SLOPE_W-1:0] clamp_slope(input logic signed [SLOPE_W-1:0] v);
    if (v > SLOPE_LIM) return SLOPE_LIM;
    if (v < -SLOPE_LIM) return -SLOPE_LIM;
    return v;
  endfunction

  function automatic logic signed [ICPT_W-1:0] clamp_icpt(input logic signed [ICPT_W-1:0] v);
    if (v > ICPT_LIM) return ICPT_LIM;
    if (v < -ICPT_LIM) return -ICPT_LIM;
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/lhmpq_if.sv =====
// Valid/ready channel interfaces for input items and result beats.
`default_nettype none
interface lhmpq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic [lhmpq_pkg::HIDX_W-1:0]          hull_index;
  logic signed [lhmpq_pkg::SLOPE_W-1:0]  slope;
  logic signed [lhmpq_pkg::ICPT_W-1:0]   intercept;
  logic signed [lhmpq_pkg::SLOPE_W-1:0]  query_x;

  modport source (output valid, kind, hull_index, slope, intercept, query_x, input ready);
  modport sink (input valid, kind, hull_index, slope, intercept, query_x, output ready);
endinterface

interface lhmpq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lhmpq_pkg::VAL_W-1:0]  best_value;
  logic [lhmpq_pkg::STAT_W-1:0]        status;

  modport source (output valid, best_value, status, input ready);
  modport sink (input valid, best_value, status, output ready);
endinterface
`default_nettype wire

// ===== sv/lhmpq_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none
module lhmpq_mul (
  input  logic                                  clk,
  input  lhmpq_pkg::mul_req_t                   req,
  output logic signed [lhmpq_pkg::PROD_W-1:0]   prod_r
);
  import lhmpq_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= req.op_a * req.op_b;
  end

endmodule
`default_nettype wire

// ===== sv/line_hull_max_pointer_query.sv =====
// Top level: monotone line hulls with pop test and pointer query on one shared multiplier.
// Add: each pop test reads two lines and runs four partial products.
// Query: each line visited reads two lines and runs two products; one memory read port and the multiplier set the pace.
// One item at a time; the next item is taken the cycle after the result is loaded.
// Reset clears the sequencer, hull sizes and pointers; the line memory is not cleared.
`default_nettype none
module line_hull_max_pointer_query #(
  parameter int HULL_COUNT = 4,
  parameter int HULL_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  lhmpq_in_if.sink     in_ch,
  lhmpq_out_if.source  out_ch
);
  import lhmpq_pkg::*;

  localparam int HW        = (HULL_COUNT > 1) ? $clog2(HULL_COUNT) : 1;
  localparam int IW        = $clog2(HULL_DEPTH);
  localparam int SW        = $clog2(HULL_DEPTH + 1);
  localparam int AW        = HW + IW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [SW-1:0] DEPTH_N = SW'(HULL_DEPTH);

  function automatic logic [HW-1:0] hull_sel(input logic [HIDX_W-1:0] idx);
    logic [HIDX_W:0] v;
    v = {1'b0, idx};
    for (int i = 0; i < (1 << HIDX_W); i++) begin
      if (v >= (HIDX_W+1)'(HULL_COUNT)) v = v - (HIDX_W+1)'(HULL_COUNT);
    end
    return HW'(v);
  endfunction

  state_t state_r, state_nxt;

  logic [SW-1:0] size_r [HULL_COUNT];
  logic [IW-1:0] ptr_r  [HULL_COUNT];

  line_t mem [MEM_DEPTH];
  line_t rdata_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  line_t wdata;

  logic [HW-1:0] h_r, h_nxt;
  logic [SW-1:0] n_r, n_nxt;
  logic [IW-1:0] p_r, p_nxt;
  logic signed [SLOPE_W-1:0] a3_r, a3_nxt, x_r, x_nxt;
  logic signed [ICPT_W-1:0]  b3_r, b3_nxt;
  line_t l1_r, l1_nxt, l2_r, l2_nxt;
  logic signed [BDIF_W-1:0] db13_r, db13_nxt, db12_r, db12_nxt;
  logic signed [ADIF_W-1:0] da21_r, da21_nxt, da31_r, da31_nxt;
  logic [2:0] step_r, step_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, term;
  logic signed [VAL_W-1:0] v1_r, v1_nxt, v2_r, v2_nxt;
  logic signed [VAL_W-1:0] res_val_r, res_val_nxt;
  status_t res_st_r, res_st_nxt;

  logic out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;
  status_t out_st_r, out_st_nxt;

  logic [SW-1:0] nm1, nm2;
  logic [SW:0] pp1;
  logic in_fire, out_load, pop, advance;
  logic [2:0] prev_step;
  mul_req_t mreq;
  logic signed [PROD_W-1:0] prod_r;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign nm1       = n_r - SW'(1);
  assign nm2       = n_r - SW'(2);
  assign pp1       = (SW+1)'(p_r) + (SW+1)'(1);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign pop       = acc_r[ACC_W-1];
  assign advance   = (pp1 < (SW+1)'(n_r)) && (v2_r > v1_r);
  assign prev_step = step_r - 3'd1;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.best_value = out_val_r;
  assign out_ch.status     = out_st_r;

  lhmpq_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod_r)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_fire) state_nxt = (in_ch.kind == KIND_ADD) ? S_ADD_CHK : S_QRY_CHK;
      S_ADD_CHK:  state_nxt = (n_r >= SW'(2)) ? S_ADD_RD0 : S_ADD_PUSH;
      S_ADD_RD0:  state_nxt = S_ADD_RD1;
      S_ADD_RD1:  state_nxt = S_ADD_LAT;
      S_ADD_LAT:  state_nxt = S_ADD_DIF;
      S_ADD_DIF:  state_nxt = S_ADD_MUL;
      S_ADD_MUL:  if (step_r == 3'd4) state_nxt = S_ADD_CMP;
      S_ADD_CMP:  state_nxt = pop ? S_ADD_CHK : S_ADD_PUSH;
      S_ADD_PUSH: state_nxt = S_DONE;
      S_QRY_CHK:  state_nxt = (n_r == '0) ? S_DONE : S_QRY_RD0;
      S_QRY_RD0:  state_nxt = S_QRY_RD1;
      S_QRY_RD1:  state_nxt = S_QRY_LAT;
      S_QRY_LAT:  state_nxt = S_QRY_M0;
      S_QRY_M0:   state_nxt = S_QRY_M1;
      S_QRY_M1:   state_nxt = S_QRY_M2;
      S_QRY_M2:   state_nxt = S_QRY_CMP;
      S_QRY_CMP:  state_nxt = advance ? S_QRY_RD0 : S_DONE;
      S_DONE:     if (out_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Memory and multiplier control
  always_comb begin
    rd_addr   = {h_r, p_r};
    wr_en     = 1'b0;
    wr_addr   = {h_r, n_r[IW-1:0]};
    wdata     = '{slope: a3_r, icpt: b3_r};
    mreq      = '0;
    case (state_r)
      S_ADD_RD0:  rd_addr = {h_r, nm2[IW-1:0]};
      S_ADD_RD1:  rd_addr = {h_r, nm1[IW-1:0]};
      S_ADD_PUSH: wr_en = (n_r < DEPTH_N);
      S_QRY_RD0:  rd_addr = {h_r, p_r};
      S_QRY_RD1:  rd_addr = {h_r, pp1[IW-1:0]};
      S_QRY_M0:   mreq = '{op_a: MOP_W'(l1_r.slope), op_b: MOP_W'(x_r)};
      S_QRY_M1:   mreq = '{op_a: MOP_W'(l2_r.slope), op_b: MOP_W'(x_r)};
      S_ADD_MUL: begin
        case (step_r)
          3'd0: mreq = '{op_a: MOP_W'($signed(db13_r[BDIF_W-1:BLO_W])), op_b: MOP_W'(da21_r)};
          3'd1: mreq = '{op_a: MOP_W'(db13_r[BLO_W-1:0]), op_b: MOP_W'(da21_r)};
          3'd2: mreq = '{op_a: MOP_W'($signed(db12_r[BDIF_W-1:BLO_W])), op_b: MOP_W'(da31_r)};
          3'd3: mreq = '{op_a: MOP_W'(db12_r[BLO_W-1:0]), op_b: MOP_W'(da31_r)};
          default: mreq = '0;
        endcase
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    h_nxt       = h_r;
    n_nxt       = n_r;
    p_nxt       = p_r;
    a3_nxt      = a3_r;
    b3_nxt      = b3_r;
    x_nxt       = x_r;
    l1_nxt      = l1_r;
    l2_nxt      = l2_r;
    db13_nxt    = db13_r;
    db12_nxt    = db12_r;
    da21_nxt    = da21_r;
    da31_nxt    = da31_r;
    step_nxt    = step_r;
    acc_nxt     = acc_r;
    v1_nxt      = v1_r;
    v2_nxt      = v2_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    term        = ACC_W'(prod_r);
    if (prev_step == 3'd0 || prev_step == 3'd2) term = term <<< BLO_W;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          h_nxt       = hull_sel(in_ch.hull_index);
          n_nxt       = size_r[h_nxt];
          a3_nxt      = clamp_slope(in_ch.slope);
          b3_nxt      = clamp_icpt(in_ch.intercept);
          x_nxt       = clamp_slope(in_ch.query_x);
          res_val_nxt = '0;
          res_st_nxt  = ST_OK;
        end
      end
      S_ADD_RD1: l1_nxt = rdata_r;
      S_ADD_LAT: l2_nxt = rdata_r;
      S_ADD_DIF: begin
        db13_nxt = BDIF_W'(l1_r.icpt) - BDIF_W'(b3_r);
        db12_nxt = BDIF_W'(l1_r.icpt) - BDIF_W'(l2_r.icpt);
        da21_nxt = ADIF_W'(l2_r.slope) - ADIF_W'(l1_r.slope);
        da31_nxt = ADIF_W'(a3_r) - ADIF_W'(l1_r.slope);
        step_nxt = 3'd0;
        acc_nxt  = '0;
      end
      S_ADD_MUL: begin
        step_nxt = step_r + 3'd1;
        if (step_r != 3'd0) begin
          acc_nxt = (prev_step >= 3'd2) ? acc_r - term : acc_r + term;
        end
      end
      S_ADD_CMP: if (pop) n_nxt = nm1;
      S_ADD_PUSH: begin
        if (n_r < DEPTH_N) n_nxt = n_r + SW'(1);
        else res_st_nxt = ST_FULL;
      end
      S_QRY_CHK: begin
        if (n_r == '0) res_st_nxt = ST_EMPTY;
        else if (SW'(ptr_r[h_r]) >= n_r) p_nxt = nm1[IW-1:0];
        else p_nxt = ptr_r[h_r];
      end
      S_QRY_RD1: l1_nxt = rdata_r;
      S_QRY_LAT: l2_nxt = rdata_r;
      S_QRY_M1:  v1_nxt = VAL_W'(prod_r) + VAL_W'(l1_r.icpt);
      S_QRY_M2:  v2_nxt = VAL_W'(prod_r) + VAL_W'(l2_r.icpt);
      S_QRY_CMP: begin
        if (advance) p_nxt = pp1[IW-1:0];
        else res_val_nxt = v1_r;
      end
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = res_val_r;
      out_st_nxt    = res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wdata;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HULL_COUNT; i++) begin
        size_r[i] <= '0;
        ptr_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_ADD_PUSH) size_r[h_r] <= n_nxt;
      if (state_r == S_QRY_CMP && !advance) ptr_r[h_r] <= p_r;
    end
  end

  always_ff @(posedge clk) begin
    h_r       <= h_nxt;
    n_r       <= n_nxt;
    p_r       <= p_nxt;
    a3_r      <= a3_nxt;
    b3_r      <= b3_nxt;
    x_r       <= x_nxt;
    l1_r      <= l1_nxt;
    l2_r      <= l2_nxt;
    db13_r    <= db13_nxt;
    db12_r    <= db12_nxt;
    da21_r    <= da21_nxt;
    da31_r    <= da31_nxt;
    step_r    <= step_nxt;
    acc_r     <= acc_nxt;
    v1_r      <= v1_nxt;
    v2_r      <= v2_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
  end

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (n_r <= DEPTH_N))
    else $error("hull size beyond depth");

  a_beat_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside done");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != ST_OK) |-> (out_val_r == '0))
    else $error("nonzero value with error status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("sequencer idle after accepted item");

endmodule
`default_nettype wire
